@@ rtl/core/timer_divider_pair_search_defines.svh @@
// Assertion macros for the timer divider pair search checker.
// Used by tdps_checker.sv; expects i_clk and i_rst_n in the scope of use.
`ifndef TIMER_DIVIDER_PAIR_SEARCH_DEFINES_SVH
`define TIMER_DIVIDER_PAIR_SEARCH_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define TDPS_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("tdps checker: property violated");

// Condition holds in the cycle after the trigger.
`define TDPS_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("tdps checker: property violated");

`endif

@@ rtl/core/tdps_pkg.sv @@
// Shared constants and types for the timer divider pair search.
// No dependencies; imported by the interfaces, the divider and the top level.
`default_nettype none

package tdps_pkg;

    localparam int DATA_W       = 32;
    localparam int FREQ_W       = 16;
    localparam int FIELD_W      = 16;
    localparam int STATUS_W     = 2;
    localparam int SEARCH_LIMIT = 1000;
    localparam int PART_WIDTH   = 16;
    // Candidate holds the square root of a 32-bit count plus the search limit.
    localparam int CAND_W       = $clog2(65535 + SEARCH_LIMIT + 1);
    localparam int CNT_W        = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] CLOCK_HZ_RESET = 32'd16000000;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WIDE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ rtl/core/tdps_ifs.sv @@
// Handshake channel interfaces: input request, result and configuration write.
// Depends on tdps_pkg for the field widths.
`default_nettype none

interface tdps_in_if;
    logic                         valid;
    logic                         ready;
    logic [tdps_pkg::FREQ_W-1:0]  frequency;
    modport source (output valid, output frequency, input ready);
    modport sink   (input valid, input frequency, output ready);
endinterface

interface tdps_out_if;
    logic                          valid;
    logic                          ready;
    logic [tdps_pkg::FIELD_W-1:0]  reload;
    logic [tdps_pkg::FIELD_W-1:0]  prescale;
    logic                          exact;
    logic [tdps_pkg::STATUS_W-1:0] status;
    modport source (output valid, output reload, output prescale, output exact,
                    output status, input ready);
    modport sink   (input valid, input reload, input prescale, input exact,
                    input status, output ready);
endinterface

interface tdps_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tdps_pkg::DATA_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/timer_divider_pair_search.sv @@
// Timer divider pair search top level: sequencer, square root steps, output register.
// Depends on tdps_pkg, the interfaces in tdps_ifs.sv and the divider tdps_div.
//
//   Port     Dir   Handshake     Carries
//   i_in     in    valid/ready   frequency
//   o_out    out   valid/ready   reload, prescale, exact, status
//   i_cfg    in    valid/ready   clock_hz write data
//
// A nonzero count takes the count division, 16 square root steps and then one division
// in the shared serial divider for each candidate tried, up to 1001 candidates.
// A zero count ends after the count division; a zero frequency skips the divider.
// The divider serves the count division and every candidate, one bit per cycle.
// Reset is synchronous and active low and restores clock_hz to 16000000.
// The next request is taken while a result waits on a stalled output.
`default_nettype none

module timer_divider_pair_search (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tdps_in_if.sink     i_in,
    tdps_out_if.source  o_out,
    tdps_cfg_if.sink    i_cfg
);
    import tdps_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [DATA_W-1:0] r_clock_hz;
    logic [DATA_W-1:0] r_count, n_count;
    logic [DATA_W-1:0] r_sq_v, n_sq_v;
    logic [DATA_W-1:0] r_root, n_root;
    logic [DATA_W-1:0] r_bit, n_bit;
    logic [CAND_W-1:0] r_cand, n_cand;
    logic [CAND_W-1:0] r_last, n_last;
    logic [DATA_W-1:0] r_quo, n_quo;
    logic              r_exact, n_exact;
    logic              r_zero, n_zero;

    logic                r_out_valid, n_out_valid;
    logic [FIELD_W-1:0]  r_reload;
    logic [FIELD_W-1:0]  r_prescale;
    logic                r_out_exact;
    logic [STATUS_W-1:0] r_status;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [DATA_W:0]   sq_sum;
    logic [DATA_W-1:0] root_step;
    logic [DATA_W-1:0] sq_v_step;
    logic [CAND_W-1:0] cand_inc;
    logic              rem_zero;
    logic              out_load;
    logic              wide;

    tdps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // One digit of the square root per cycle.
    always_comb begin
        sq_sum = {1'b0, r_root} + {1'b0, r_bit};
        if ({1'b0, r_sq_v} >= sq_sum) begin
            sq_v_step = r_sq_v - sq_sum[DATA_W-1:0];
            root_step = (r_root >> 1) + r_bit;
        end else begin
            sq_v_step = r_sq_v;
            root_step = r_root >> 1;
        end
    end

    assign cand_inc = r_cand + CAND_W'(1);
    assign rem_zero = div_rsp.remainder == '0;
    assign out_load = (r_state == S_FIN) && (!r_out_valid || o_out.ready);
    assign wide     = ((DATA_W'(r_cand) >> PART_WIDTH) != '0) || ((r_quo >> PART_WIDTH) != '0);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_sq_v   = r_sq_v;
        n_root   = r_root;
        n_bit    = r_bit;
        n_cand   = r_cand;
        n_last   = r_last;
        n_quo    = r_quo;
        n_exact  = r_exact;
        n_zero   = r_zero;
        div_req.start    = 1'b0;
        div_req.dividend = r_count;
        div_req.divisor  = DATA_W'(r_cand);

        unique case (r_state)
            S_IDLE: begin
                div_req.dividend = r_clock_hz;
                div_req.divisor  = DATA_W'(i_in.frequency);
                if (i_in.valid) begin
                    if (i_in.frequency == '0) begin
                        n_zero  = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_zero        = 1'b0;
                        div_req.start = 1'b1;
                        n_state       = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_count = div_rsp.quotient;
                    if (div_rsp.quotient == '0) begin
                        n_zero  = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_sq_v  = div_rsp.quotient;
                        n_root  = '0;
                        n_bit   = DATA_W'(1) << (DATA_W - 2);
                        n_state = S_SQRT;
                    end
                end
            end
            S_SQRT: begin
                n_sq_v = sq_v_step;
                n_root = root_step;
                n_bit  = r_bit >> 2;
                if (r_bit[0]) begin
                    // Last digit: the root is the first candidate.
                    n_cand          = root_step[CAND_W-1:0];
                    n_last          = root_step[CAND_W-1:0] + CAND_W'(SEARCH_LIMIT);
                    div_req.start   = 1'b1;
                    div_req.divisor = root_step;
                    n_state         = S_MOD;
                end
            end
            S_MOD: begin
                if (div_rsp.done) begin
                    if (rem_zero || r_cand >= r_last) begin
                        n_quo   = div_rsp.quotient;
                        n_exact = rem_zero;
                        n_state = S_FIN;
                    end else begin
                        n_cand          = cand_inc;
                        div_req.start   = 1'b1;
                        div_req.divisor = DATA_W'(cand_inc);
                    end
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_clock_hz  <= CLOCK_HZ_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_clock_hz <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        r_sq_v  <= n_sq_v;
        r_root  <= n_root;
        r_bit   <= n_bit;
        r_cand  <= n_cand;
        r_last  <= n_last;
        r_quo   <= n_quo;
        r_exact <= n_exact;
        r_zero  <= n_zero;
        if (out_load) begin
            if (r_zero) begin
                r_reload    <= '0;
                r_prescale  <= '0;
                r_out_exact <= 1'b0;
                r_status    <= STATUS_ZERO;
            end else begin
                r_reload    <= FIELD_W'(r_cand);
                r_prescale  <= r_quo[FIELD_W-1:0];
                r_out_exact <= r_exact;
                r_status    <= wide ? STATUS_WIDE : STATUS_OK;
            end
        end
    end

    assign i_in.ready     = r_state == S_IDLE;
    assign i_cfg.ready    = 1'b1;
    assign o_out.valid    = r_out_valid;
    assign o_out.reload   = r_reload;
    assign o_out.prescale = r_prescale;
    assign o_out.exact    = r_out_exact;
    assign o_out.status   = r_status;

endmodule

`default_nettype wire

@@ rtl/core/tdps_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Depends on tdps_pkg for widths and the request and response structs.
`default_nettype none

module tdps_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  tdps_pkg::t_div_req i_req,
    output tdps_pkg::t_div_rsp o_rsp
);
    import tdps_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_div;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              ge;
    logic [DATA_W-1:0] n_rem;
    logic [DATA_W-1:0] n_quo;

    always_comb begin
        shifted = {r_rem, r_quo[DATA_W-1]};
        diff    = shifted - {1'b0, r_div};
        ge      = shifted >= {1'b0, r_div};
        // The partial remainder stays below the divisor, so it fits DATA_W bits.
        n_rem   = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        n_quo   = {r_quo[DATA_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W - 1);
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

@@ rtl/core/tdps_checker.sv @@
// Port-level checker for the timer divider pair search, with its bind statement.
// Depends on tdps_pkg and the macros in timer_divider_pair_search_defines.svh.
`default_nettype none
`include "timer_divider_pair_search_defines.svh"

module tdps_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          i_in_ready,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [tdps_pkg::FIELD_W-1:0]  i_reload,
    input wire [tdps_pkg::FIELD_W-1:0]  i_prescale,
    input wire                          i_exact,
    input wire [tdps_pkg::STATUS_W-1:0] i_status
);
    import tdps_pkg::*;

    // A stalled result keeps its fields.
    `TDPS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable({i_reload, i_prescale, i_exact, i_status}))

    // Every request leaves the idle state, so ready drops after an accept.
    `TDPS_ASSERT_NEXT(a_busy_after_req, i_in_valid && i_in_ready, !i_in_ready)

    // A zero count or frequency reports all result fields cleared.
    `TDPS_ASSERT_SAME(a_zero_fields, i_out_valid && i_status == STATUS_ZERO,
        i_reload == '0 && i_prescale == '0 && !i_exact)

    // A good result always has a nonzero reload, since the candidate is at least one.
    `TDPS_ASSERT_SAME(a_ok_reload, i_out_valid && i_status == STATUS_OK, i_reload != '0)

endmodule

bind timer_divider_pair_search tdps_checker u_tdps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_reload    (o_out.reload),
    .i_prescale  (o_out.prescale),
    .i_exact     (o_out.exact),
    .i_status    (o_out.status)
);

`default_nettype wire

@@ test/tb_timer_divider_pair_search.sv @@
// Testbench for timer_divider_pair_search: directed and random frequency requests
// checked against an in-bench predictor. Needs tdps_pkg and tdps_ifs.sv from the RTL.
`timescale 1ns / 100ps

module tb_timer_divider_pair_search;
    import tdps_pkg::*;

    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 13;
    localparam logic [63:0] PART_MAX = (64'd1 << PART_WIDTH) - 1;

    typedef struct packed {
        logic [FIELD_W-1:0]  reload;
        logic [FIELD_W-1:0]  prescale;
        logic                exact;
        logic [STATUS_W-1:0] status;
    } t_split;

    class split_scoreboard;
        logic [DATA_W-1:0] clock_hz;
        t_split awaited_splits[$];
        int mismatches;

        function new();
            clock_hz = CLOCK_HZ_RESET;
            mismatches = 0;
        endfunction

        // Count is clock over frequency; the search walks up from its square root.
        function t_split split_count(input logic [FREQ_W-1:0] freq);
            t_split r;
            logic [63:0] count, root, trial, cand, last, other;
            r = '0;
            r.status = STATUS_ZERO;
            if (freq == '0) return r;
            count = 64'(clock_hz) / 64'(freq);
            if (count == 0) return r;
            root = 0;
            for (int b = 15; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= count) root = trial;
            end
            cand = root;
            last = root + SEARCH_LIMIT;
            while ((count % cand) != 0 && cand < last) cand++;
            other = count / cand;
            r.reload = cand[FIELD_W-1:0];
            r.prescale = other[FIELD_W-1:0];
            r.exact = ((count % cand) == 0);
            r.status = (cand > PART_MAX || other > PART_MAX) ? STATUS_WIDE : STATUS_OK;
            return r;
        endfunction

        function void note_frequency(input logic [FREQ_W-1:0] freq);
            awaited_splits.push_back(split_count(freq));
        endfunction

        function void check_split(input t_split got);
            t_split want;
            if (awaited_splits.size() == 0) begin
                $error("unexpected result: reload %0d prescale %0d", got.reload, got.prescale);
                mismatches++;
                return;
            end
            want = awaited_splits.pop_front();
            if (got.reload !== want.reload) begin
                $error("reload: expected %0d, actual %0d", want.reload, got.reload);
                mismatches++;
            end
            if (got.prescale !== want.prescale) begin
                $error("prescale: expected %0d, actual %0d", want.prescale, got.prescale);
                mismatches++;
            end
            if (got.exact !== want.exact) begin
                $error("exact: expected %0d, actual %0d", want.exact, got.exact);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic tb_clk = 1'b0;
    logic tb_rst_n;
    bit steady_flow;
    split_scoreboard sb = new();

    tdps_in_if  req_ch();
    tdps_out_if res_ch();
    tdps_cfg_if cfg_ch();

    timer_divider_pair_search dut (
        .i_clk   (tb_clk),
        .i_rst_n (tb_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #4 tb_clk = 1'b1;
        #4 tb_clk = 1'b0;
    end

    // Requests are noted before results are checked, so a same-edge pair stays ordered.
    always @(posedge tb_clk) begin
        if (tb_rst_n === 1'b1) begin
            if (req_ch.valid && req_ch.ready) sb.note_frequency(req_ch.frequency);
            if (res_ch.valid && res_ch.ready)
                sb.check_split('{res_ch.reload, res_ch.prescale, res_ch.exact, res_ch.status});
        end
    end

    task automatic send_frequency(input logic [FREQ_W-1:0] freq);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge tb_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.frequency <= freq;
        do @(posedge tb_clk); while (!req_ch.ready);
    endtask

    // Drain every result, then write the clock register while the block is idle.
    task automatic write_clock(input logic [DATA_W-1:0] value);
        req_ch.valid <= 1'b0;
        do @(posedge tb_clk); while (sb.awaited_splits.size() != 0);
        repeat (4) @(posedge tb_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do @(posedge tb_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.clock_hz = value;
    endtask

    function automatic logic [FREQ_W-1:0] draw_frequency();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick <= 2) return FREQ_W'($urandom_range(1, 255));
        return FREQ_W'($urandom_range(0, 65535));
    endfunction

    initial begin : result_sink
        int stall;
        wait (tb_rst_n === 1'b1);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge tb_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge tb_clk); while (res_ch.valid !== 1'b1);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge tb_clk);
            cycles++;
        end
        $display("timer_divider_pair_search verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [DATA_W-1:0] clock_value;
        tb_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.frequency <= '0;
        res_ch.ready <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        steady_flow = 1'b0;
        repeat (3) @(posedge tb_clk);
        tb_rst_n <= 1'b1;
        @(posedge tb_clk);

        // Reset clock value: zero frequency, field extremes, alternating bit patterns.
        send_frequency(16'd0);
        send_frequency(16'd1);
        send_frequency(16'hFFFF);
        send_frequency(16'h8000);
        send_frequency(16'h5555);
        send_frequency(16'hAAAA);
        send_frequency(16'd16000);

        // Full-scale clock: an oversized prescale, and searches that run out.
        write_clock(32'hFFFF_FFFF);
        send_frequency(16'd1);
        send_frequency(16'd2);
        send_frequency(16'hFFFF);

        // A prime count near the top pushes the candidate past 16 bits.
        write_clock(32'd4294967291);
        send_frequency(16'd1);

        // Small prime count too far from its root to be reached within the limit.
        write_clock(32'd2003);
        send_frequency(16'd1);
        send_frequency(16'd3000);

        // Small prime count that the search does reach, then count of one and zero.
        write_clock(32'd13);
        send_frequency(16'd1);
        send_frequency(16'd13);
        send_frequency(16'd14);

        write_clock(32'd1);
        send_frequency(16'd1);
        send_frequency(16'd2);

        write_clock(32'd0);
        send_frequency(16'd1);
        send_frequency(16'hFFFF);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: clock_value = CLOCK_HZ_RESET;
                1: clock_value = DATA_W'($urandom());
                2: clock_value = DATA_W'($urandom_range(0, 200000));
                3: clock_value = 32'hFFFF_FFFF;
                4: clock_value = DATA_W'($urandom_range(1, 65535));
                default: clock_value = DATA_W'($urandom());
            endcase
            write_clock(clock_value);
            steady_flow = (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) send_frequency(draw_frequency());
        end
        steady_flow = 1'b0;

        req_ch.valid <= 1'b0;
        do @(posedge tb_clk); while (sb.awaited_splits.size() != 0);
        repeat (64) @(posedge tb_clk);
        if (sb.mismatches == 0) begin
            $display("timer_divider_pair_search verification clean");
        end else begin
            $display("timer_divider_pair_search verification failed");
        end
        $finish;
    end

endmodule
